// ===== rtl/liu_pkg.sv =====
// Shared types and constants for the logical instruction unit.
// Depends on nothing; used by liu_ctrl, liu_datapath and the top level.
package liu_pkg;

    localparam int BYTE_W = 8;

    // Item kinds carried on s_tuser
    localparam logic [1:0] KIND_MEM_WR   = 2'd0;
    localparam logic [1:0] KIND_SET_REGS = 2'd1;
    localparam logic [1:0] KIND_EXEC     = 2'd2;

    // Opcode fields and special opcodes
    localparam logic [7:0] OP_BIT_ZP  = 8'h24;
    localparam logic [7:0] OP_BIT_ABS = 8'h2C;
    localparam logic [1:0] CC_ALU     = 2'b01;

    localparam logic [2:0] GRP_ORA = 3'd0;
    localparam logic [2:0] GRP_AND = 3'd1;
    localparam logic [2:0] GRP_EOR = 3'd2;

    localparam logic [2:0] MODE_IND_X = 3'd0;
    localparam logic [2:0] MODE_ZP    = 3'd1;
    localparam logic [2:0] MODE_IMM   = 3'd2;
    localparam logic [2:0] MODE_ABS   = 3'd3;
    localparam logic [2:0] MODE_IND_Y = 3'd4;
    localparam logic [2:0] MODE_ZP_X  = 3'd5;
    localparam logic [2:0] MODE_ABS_Y = 3'd6;
    localparam logic [2:0] MODE_ABS_X = 3'd7;

    typedef enum logic [1:0] {
        ALU_ORA,
        ALU_AND,
        ALU_EOR,
        ALU_BIT
    } alu_op_t;

    typedef enum logic [3:0] {
        ADDR_PC,
        ADDR_ZP,
        ADDR_ZP1,
        ADDR_ZPX,
        ADDR_ZPX1,
        ADDR_ABS,
        ADDR_ABSX,
        ADDR_ABSY,
        ADDR_IND,
        ADDR_INDY
    } addr_sel_t;

    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_B0,
        CAP_HI,
        CAP_PLO
    } cap_sel_t;

    typedef struct packed {
        logic      mem_wr;
        logic      set_regs;
        logic      load_op;
        logic      rd_en;
        addr_sel_t addr_sel;
        cap_sel_t  cap_sel;
        logic      pc_inc;
        logic      alu_en;
        alu_op_t   alu_op;
        logic      load_out;
        logic      out_illegal;
    } liu_cmd_t;

    typedef struct packed {
        logic [7:0] opcode;
    } liu_status_t;

endpackage

// ===== rtl/liu_ctrl.sv =====
// Controller for the logical instruction unit: item handshake, opcode decode
// and the per-mode fetch sequence. Depends on liu_pkg.
module liu_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           kind,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  liu_pkg::liu_status_t status,
    output liu_pkg::liu_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_F0,
        ST_B0,
        ST_HI,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_RD,
        ST_EX,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   illegal_reg;

    logic       accept;
    logic [2:0] mode;
    logic [2:0] group;
    logic       is_bit;
    logic       legal;
    logic       abs_mode;
    logic       ind_mode;

    // Decode the held opcode
    assign mode     = status.opcode[4:2];
    assign group    = status.opcode[7:5];
    assign is_bit   = (status.opcode == liu_pkg::OP_BIT_ZP) ||
                      (status.opcode == liu_pkg::OP_BIT_ABS);
    assign legal    = is_bit ||
                      ((status.opcode[1:0] == liu_pkg::CC_ALU) && (group <= liu_pkg::GRP_EOR));
    assign abs_mode = (mode == liu_pkg::MODE_ABS) || (mode == liu_pkg::MODE_ABS_Y) ||
                      (mode == liu_pkg::MODE_ABS_X);
    assign ind_mode = (mode == liu_pkg::MODE_IND_X) || (mode == liu_pkg::MODE_IND_Y);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;

    // Command decode per state
    always_comb
    begin
        cmd             = '0;
        cmd.addr_sel    = liu_pkg::ADDR_PC;
        cmd.cap_sel     = liu_pkg::CAP_NONE;
        cmd.alu_op      = liu_pkg::ALU_ORA;
        cmd.out_illegal = illegal_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.mem_wr   = accept && (kind == liu_pkg::KIND_MEM_WR);
                cmd.set_regs = accept && (kind == liu_pkg::KIND_SET_REGS);
                cmd.load_op  = accept;
            end
            ST_F0:
            begin
                cmd.rd_en  = legal;
                cmd.pc_inc = legal;
            end
            ST_B0:
            begin
                cmd.cap_sel = liu_pkg::CAP_B0;
                cmd.rd_en   = abs_mode;
                cmd.pc_inc  = abs_mode;
            end
            ST_HI:
            begin
                cmd.cap_sel = liu_pkg::CAP_HI;
            end
            ST_P0:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = (mode == liu_pkg::MODE_IND_X) ? liu_pkg::ADDR_ZPX
                                                             : liu_pkg::ADDR_ZP;
            end
            ST_P1:
            begin
                cmd.rd_en    = 1'b1;
                cmd.cap_sel  = liu_pkg::CAP_PLO;
                cmd.addr_sel = (mode == liu_pkg::MODE_IND_X) ? liu_pkg::ADDR_ZPX1
                                                             : liu_pkg::ADDR_ZP1;
            end
            ST_P2:
            begin
                cmd.cap_sel = liu_pkg::CAP_HI;
            end
            ST_RD:
            begin
                cmd.rd_en = 1'b1;
                unique case (mode)
                    liu_pkg::MODE_IND_X: cmd.addr_sel = liu_pkg::ADDR_IND;
                    liu_pkg::MODE_IND_Y: cmd.addr_sel = liu_pkg::ADDR_INDY;
                    liu_pkg::MODE_ZP:    cmd.addr_sel = liu_pkg::ADDR_ZP;
                    liu_pkg::MODE_ZP_X:  cmd.addr_sel = liu_pkg::ADDR_ZPX;
                    liu_pkg::MODE_ABS:   cmd.addr_sel = liu_pkg::ADDR_ABS;
                    liu_pkg::MODE_ABS_Y: cmd.addr_sel = liu_pkg::ADDR_ABSY;
                    liu_pkg::MODE_ABS_X: cmd.addr_sel = liu_pkg::ADDR_ABSX;
                    default:             cmd.addr_sel = liu_pkg::ADDR_PC;
                endcase
            end
            ST_EX:
            begin
                cmd.alu_en = 1'b1;
                priority if (is_bit)
                    cmd.alu_op = liu_pkg::ALU_BIT;
                else if (group == liu_pkg::GRP_AND)
                    cmd.alu_op = liu_pkg::ALU_AND;
                else if (group == liu_pkg::GRP_EOR)
                    cmd.alu_op = liu_pkg::ALU_EOR;
                else
                    cmd.alu_op = liu_pkg::ALU_ORA;
            end
            ST_DONE:
            begin
                cmd.load_out = !m_valid_reg || m_tready;
            end
            default:
            begin
                cmd.load_out = 1'b0;
            end
        endcase
    end

    // Sequence state, result valid and illegal flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            illegal_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        illegal_reg <= 1'b0;
                        state_reg   <= (kind == liu_pkg::KIND_EXEC) ? ST_F0 : ST_DONE;
                    end
                end
                ST_F0:
                begin
                    priority if (!legal)
                    begin
                        illegal_reg <= 1'b1;
                        state_reg   <= ST_DONE;
                    end
                    else if (mode == liu_pkg::MODE_IMM && !is_bit)
                        state_reg <= ST_EX;
                    else
                        state_reg <= ST_B0;
                end
                ST_B0:
                begin
                    priority if (abs_mode)
                        state_reg <= ST_HI;
                    else if (ind_mode)
                        state_reg <= ST_P0;
                    else
                        state_reg <= ST_RD;
                end
                ST_HI:   state_reg <= ST_RD;
                ST_P0:   state_reg <= ST_P1;
                ST_P1:   state_reg <= ST_P2;
                ST_P2:   state_reg <= ST_RD;
                ST_RD:   state_reg <= ST_EX;
                ST_EX:   state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (cmd.load_out)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Memory is written only by an accepted write item
    a_wr_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> (s_tvalid && s_tready))
        else $error("memory write without an accepted item");

    // One item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is at work");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten before it was taken");

endmodule

// ===== rtl/liu_datapath.sv =====
// Datapath for the logical instruction unit: byte memory, architectural
// registers, address generation, logic unit and result register. Uses liu_pkg.
module liu_datapath
#(
    parameter int ADDR_WIDTH = 16,
    parameter int S_DATA_W   = 72,
    parameter int M_DATA_W   = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  liu_pkg::liu_cmd_t     cmd,
    output liu_pkg::liu_status_t  status,
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tuser
);

    localparam int BW        = liu_pkg::BYTE_W;
    localparam int OPC_LSB   = 0;
    localparam int MADDR_LSB = OPC_LSB + BW;
    localparam int MDATA_LSB = MADDR_LSB + ADDR_WIDTH;
    localparam int SACC_LSB  = MDATA_LSB + BW;
    localparam int SX_LSB    = SACC_LSB + BW;
    localparam int SY_LSB    = SX_LSB + BW;
    localparam int SPC_LSB   = SY_LSB + BW;
    localparam int MEM_DEPTH = 1 << ADDR_WIDTH;

    logic [BW-1:0] mem [0:MEM_DEPTH-1];

    logic [BW-1:0]         rdata_reg;
    logic [BW-1:0]         opcode_reg;
    logic [BW-1:0]         b0_reg;
    logic [BW-1:0]         hi_reg;
    logic [BW-1:0]         plo_reg;
    logic [BW-1:0]         acc_reg;
    logic [BW-1:0]         x_reg;
    logic [BW-1:0]         y_reg;
    logic [ADDR_WIDTH-1:0] pc_reg;
    logic                  n_reg;
    logic                  z_reg;
    logic                  v_reg;

    logic [BW-1:0]         out_acc_reg;
    logic [ADDR_WIDTH-1:0] out_pc_reg;
    logic                  out_n_reg;
    logic                  out_z_reg;
    logic                  out_v_reg;
    logic                  out_ill_reg;

    logic [BW-1:0]         acc_next;
    logic                  n_next;
    logic                  z_next;
    logic                  v_next;
    logic [ADDR_WIDTH-1:0] rd_addr;
    logic [BW-1:0]         zpx;
    logic [ADDR_WIDTH-1:0] abs_base;
    logic [ADDR_WIDTH-1:0] ind_base;

    assign status.opcode = opcode_reg;

    // Address generation; page-zero sums wrap at eight bits
    assign zpx      = b0_reg + x_reg;
    assign abs_base = ADDR_WIDTH'({hi_reg, b0_reg});
    assign ind_base = ADDR_WIDTH'({hi_reg, plo_reg});

    always_comb
    begin
        unique case (cmd.addr_sel)
            liu_pkg::ADDR_PC:   rd_addr = pc_reg;
            liu_pkg::ADDR_ZP:   rd_addr = ADDR_WIDTH'(b0_reg);
            liu_pkg::ADDR_ZP1:  rd_addr = ADDR_WIDTH'(BW'(b0_reg + 1'b1));
            liu_pkg::ADDR_ZPX:  rd_addr = ADDR_WIDTH'(zpx);
            liu_pkg::ADDR_ZPX1: rd_addr = ADDR_WIDTH'(BW'(zpx + 1'b1));
            liu_pkg::ADDR_ABS:  rd_addr = abs_base;
            liu_pkg::ADDR_ABSX: rd_addr = abs_base + ADDR_WIDTH'(x_reg);
            liu_pkg::ADDR_ABSY: rd_addr = abs_base + ADDR_WIDTH'(y_reg);
            liu_pkg::ADDR_IND:  rd_addr = ind_base;
            liu_pkg::ADDR_INDY: rd_addr = ind_base + ADDR_WIDTH'(y_reg);
            default:            rd_addr = pc_reg;
        endcase
    end

    // Memory: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
            mem[s_tdata[MADDR_LSB +: ADDR_WIDTH]] <= s_tdata[MDATA_LSB +: BW];
        if (cmd.rd_en)
            rdata_reg <= mem[rd_addr];
    end

    // Logic unit on the last byte read
    always_comb
    begin
        acc_next = acc_reg;
        n_next   = n_reg;
        z_next   = z_reg;
        v_next   = v_reg;
        unique case (cmd.alu_op)
            liu_pkg::ALU_ORA: acc_next = acc_reg | rdata_reg;
            liu_pkg::ALU_AND: acc_next = acc_reg & rdata_reg;
            liu_pkg::ALU_EOR: acc_next = acc_reg ^ rdata_reg;
            default:          acc_next = acc_reg;
        endcase
        if (cmd.alu_op == liu_pkg::ALU_BIT)
        begin
            z_next = ((acc_reg & rdata_reg) == '0);
            n_next = rdata_reg[BW-1];
            v_next = rdata_reg[BW-2];
        end
        else
        begin
            z_next = (acc_next == '0);
            n_next = acc_next[BW-1];
        end
    end

    // Operand and pointer bytes, held opcode and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
            opcode_reg <= s_tdata[OPC_LSB +: BW];
        unique case (cmd.cap_sel)
            liu_pkg::CAP_B0:  b0_reg  <= rdata_reg;
            liu_pkg::CAP_HI:  hi_reg  <= rdata_reg;
            liu_pkg::CAP_PLO: plo_reg <= rdata_reg;
            default:          b0_reg  <= b0_reg;
        endcase
        if (cmd.load_out)
        begin
            out_acc_reg <= acc_reg;
            out_pc_reg  <= pc_reg;
            out_n_reg   <= n_reg;
            out_z_reg   <= z_reg;
            out_v_reg   <= v_reg;
            out_ill_reg <= cmd.out_illegal;
        end
    end

    // Architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            x_reg   <= '0;
            y_reg   <= '0;
            pc_reg  <= '0;
            n_reg   <= 1'b0;
            z_reg   <= 1'b0;
            v_reg   <= 1'b0;
        end
        else
        begin
            priority if (cmd.set_regs)
            begin
                acc_reg <= s_tdata[SACC_LSB +: BW];
                x_reg   <= s_tdata[SX_LSB +: BW];
                y_reg   <= s_tdata[SY_LSB +: BW];
                pc_reg  <= s_tdata[SPC_LSB +: ADDR_WIDTH];
            end
            else if (cmd.pc_inc)
                pc_reg <= pc_reg + 1'b1;
            else if (cmd.alu_en)
            begin
                acc_reg <= acc_next;
                n_reg   <= n_next;
                z_reg   <= z_next;
                v_reg   <= v_next;
            end
        end
    end

    assign m_tdata = M_DATA_W'({out_pc_reg, out_v_reg, out_z_reg, out_n_reg, out_acc_reg});
    assign m_tuser = out_ill_reg;

endmodule

// ===== rtl/logical_instruction_unit.sv =====
// Logical instruction unit: AND, EOR, ORA and BIT over a byte memory.
// Write, set and ignored items go from acceptance straight to the result state; an opcode
// item reads its first byte (F0), then an unhandled opcode ends, immediate goes to EX, page zero
// runs B0, RD, EX, absolute B0, HI, RD, EX and indirect B0, P0, P1, P2, RD, EX. One item at a time;
// the single memory read port reads one byte per cycle. Depends on liu_pkg, liu_ctrl, liu_datapath.
// rst_n clears A, X, Y, PC, the flags and the handshake; memory is not cleared.
module logical_instruction_unit
#(
    parameter int ADDR_WIDTH = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // opcode, mem_address, mem_data, set_acc, set_x, set_y, set_pc (lowest first)
    input  logic [((40 + 2*ADDR_WIDTH + 7) / 8)*8-1:0] s_tdata,
    // kind
    input  logic [1:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // acc, flag_n, flag_z, flag_v, pc, zero fill (lowest first)
    output logic [((11 + ADDR_WIDTH + 7) / 8)*8-1:0] m_tdata,
    // illegal
    output logic                                   m_tuser
);

    localparam int S_DATA_W = ((40 + 2*ADDR_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W = ((11 + ADDR_WIDTH + 7) / 8) * 8;

    liu_pkg::liu_cmd_t    cmd;
    liu_pkg::liu_status_t status;

    // Sequencer
    liu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Memory, registers and logic unit
    liu_datapath
    #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .S_DATA_W   (S_DATA_W),
        .M_DATA_W   (M_DATA_W)
    )
    u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for logical_instruction_unit: drives memory, register and opcode
// items over the stream ports and compares every result with a shadow copy of the unit.
// Depends on liu_pkg and the logical_instruction_unit RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          RANDOM_ITEMS  = 900;
    localparam int          PRESSURE_AT   = 300;
    localparam int          PRESSURE_LEN  = 250;
    localparam int          SHOW_LIMIT    = 10;
    localparam logic [1:0]  KIND_IGNORED  = 2'd3;
    localparam logic [7:0]  OP_BRK        = 8'h00;
    localparam logic [7:0]  OP_ADC_IMM    = 8'h69;
    localparam logic [7:0]  OP_ALL_ONES   = 8'hFF;

    // Registers and flags as seen after one item
    typedef struct packed {
        logic [7:0]  acc;
        logic        n;
        logic        z;
        logic        v;
        logic [15:0] pc;
        logic        illegal;
    } reg_snapshot_t;

    // Shadow copy of the unit: memory, registers, and the snapshots still owed by the RTL
    class liu_shadow;
        bit   [7:0]    mem [65536];
        bit            written [65536];
        logic [7:0]    acc_reg;
        logic [7:0]    x_reg;
        logic [7:0]    y_reg;
        logic [15:0]   pc_reg;
        logic          n_flag;
        logic          z_flag;
        logic          v_flag;
        reg_snapshot_t owed[$];
        int            errors;
        int            results;
        int            items;
        int            n_exec;
        int            n_bad;
        int            n_wr;
        int            n_set;

        function new();
            acc_reg = 8'h00;
            x_reg   = 8'h00;
            y_reg   = 8'h00;
            pc_reg  = 16'h0000;
            n_flag  = 1'b0;
            z_flag  = 1'b0;
            v_flag  = 1'b0;
            errors  = 0;
            results = 0;
            items   = 0;
            n_exec  = 0;
            n_bad   = 0;
            n_wr    = 0;
            n_set   = 0;
        endfunction

        function logic [7:0] next_byte();
            logic [7:0] b;
            b      = mem[pc_reg];
            pc_reg = pc_reg + 16'd1;
            return b;
        endfunction

        // Execute one opcode; return 1 when it is not handled
        function bit run_opcode(logic [7:0] op);
            logic [7:0]  b0;
            logic [7:0]  hi;
            logic [7:0]  zp;
            logic [7:0]  zp1;
            logic [7:0]  m;
            logic [15:0] ea;
            if (op == liu_pkg::OP_BIT_ZP || op == liu_pkg::OP_BIT_ABS)
            begin
                b0 = next_byte();
                if (op == liu_pkg::OP_BIT_ABS)
                begin
                    hi = next_byte();
                    ea = {hi, b0};
                end
                else
                    ea = {8'h00, b0};
                m      = mem[ea];
                z_flag = ((acc_reg & m) == 8'h00);
                n_flag = m[7];
                v_flag = m[6];
                return 1'b0;
            end
            if (op[1:0] != liu_pkg::CC_ALU || op[7:5] > liu_pkg::GRP_EOR)
                return 1'b1;
            b0 = next_byte();
            unique case (op[4:2])
                liu_pkg::MODE_IND_X:
                begin
                    zp  = b0 + x_reg;
                    zp1 = zp + 8'd1;
                    ea  = {mem[{8'h00, zp1}], mem[{8'h00, zp}]};
                    m   = mem[ea];
                end
                liu_pkg::MODE_ZP:    m = mem[{8'h00, b0}];
                liu_pkg::MODE_IMM:   m = b0;
                liu_pkg::MODE_ABS:
                begin
                    hi = next_byte();
                    m  = mem[{hi, b0}];
                end
                liu_pkg::MODE_IND_Y:
                begin
                    zp1 = b0 + 8'd1;
                    ea  = {mem[{8'h00, zp1}], mem[{8'h00, b0}]} + {8'h00, y_reg};
                    m   = mem[ea];
                end
                liu_pkg::MODE_ZP_X:
                begin
                    zp = b0 + x_reg;
                    m  = mem[{8'h00, zp}];
                end
                liu_pkg::MODE_ABS_Y:
                begin
                    hi = next_byte();
                    ea = {hi, b0} + {8'h00, y_reg};
                    m  = mem[ea];
                end
                default:
                begin
                    hi = next_byte();
                    ea = {hi, b0} + {8'h00, x_reg};
                    m  = mem[ea];
                end
            endcase
            unique case (op[7:5])
                liu_pkg::GRP_ORA: acc_reg = acc_reg | m;
                liu_pkg::GRP_AND: acc_reg = acc_reg & m;
                default:          acc_reg = acc_reg ^ m;
            endcase
            n_flag = acc_reg[7];
            z_flag = (acc_reg == 8'h00);
            return 1'b0;
        endfunction

        // Apply one accepted input item and queue the snapshot it must produce
        function void accept_item(logic [1:0] kind, logic [71:0] d);
            reg_snapshot_t s;
            bit            bad;
            bad = 1'b0;
            unique case (kind)
                liu_pkg::KIND_MEM_WR:
                begin
                    mem[d[23:8]]     = d[31:24];
                    written[d[23:8]] = 1'b1;
                    n_wr++;
                end
                liu_pkg::KIND_SET_REGS:
                begin
                    acc_reg = d[39:32];
                    x_reg   = d[47:40];
                    y_reg   = d[55:48];
                    pc_reg  = d[71:56];
                    n_set++;
                end
                liu_pkg::KIND_EXEC:
                begin
                    bad = run_opcode(d[7:0]);
                    n_exec++;
                    if (bad)
                        n_bad++;
                end
                default: ;
            endcase
            if (kind != KIND_IGNORED)
                items++;
            s.acc     = acc_reg;
            s.n       = n_flag;
            s.z       = z_flag;
            s.v       = v_flag;
            s.pc      = pc_reg;
            s.illegal = bad;
            owed.push_back(s);
        endfunction

        // Compare one accepted result with the oldest owed snapshot
        function void check_result(logic [31:0] d, logic ill);
            reg_snapshot_t e;
            results++;
            if (owed.size() == 0)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("result %0d: nothing expected, got %s%h n=%b z=%b v=%b pc=%h ill=%b",
                             results, "acc=", d[7:0], d[8], d[9], d[10], d[26:11], ill);
                return;
            end
            e = owed.pop_front();
            if (d[7:0] !== e.acc || d[8] !== e.n || d[9] !== e.z || d[10] !== e.v ||
                d[26:11] !== e.pc || ill !== e.illegal)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                begin
                    $display("result %0d: expected acc=%h n=%b z=%b v=%b pc=%h ill=%b",
                             results, e.acc, e.n, e.z, e.v, e.pc, e.illegal);
                    $display("result %0d: actual   acc=%h n=%b z=%b v=%b pc=%h ill=%b",
                             results, d[7:0], d[8], d[9], d[10], d[26:11], ill);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // opcode, mem_address, mem_data, set_acc, set_x, set_y, set_pc
    logic [1:0]  s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // acc, flag_n, flag_z, flag_v, pc, zero fill
    logic        m_tuser;   // illegal

    liu_shadow   sb;
    logic [15:0] chain_addrs[$];
    int          cycles;

    logical_instruction_unit #(.ADDR_WIDTH(16)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Random helpers
    function automatic logic [71:0] noise72();
        logic [95:0] r;
        r = {$urandom(), $urandom(), $urandom()};
        return r[71:0];
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [15:0] pick_pc();
        if ($urandom_range(4) == 0)
            return 16'hFFFC + 16'($urandom_range(3));
        return 16'($urandom_range(65535));
    endfunction

    function automatic logic [7:0] pick_legal();
        logic [2:0] grp;
        logic [2:0] mode;
        if ($urandom_range(9) < 2)
            return ($urandom_range(1) != 0) ? liu_pkg::OP_BIT_ABS : liu_pkg::OP_BIT_ZP;
        grp  = 3'($urandom_range(2));
        mode = 3'($urandom_range(7));
        return {grp, mode, liu_pkg::CC_ALU};
    endfunction

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Offer one item and hold it until accepted
    task automatic send(input logic [1:0] kind, input logic [71:0] d);
        int g;
        g = idle_cycles();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.accept_item(kind, d);
    endtask

    task automatic write_byte(input logic [15:0] addr, input logic [7:0] val);
        logic [71:0] d;
        d        = noise72();
        d[23:8]  = addr;
        d[31:24] = val;
        send(liu_pkg::KIND_MEM_WR, d);
    endtask

    task automatic set_regs(input logic [7:0] a, input logic [7:0] x, input logic [7:0] y,
                            input logic [15:0] pc);
        logic [71:0] d;
        d        = noise72();
        d[39:32] = a;
        d[47:40] = x;
        d[55:48] = y;
        d[71:56] = pc;
        send(liu_pkg::KIND_SET_REGS, d);
    endtask

    // Make sure a byte the coming opcode reads holds a known value; keep bytes already
    // placed for this opcode so the address chain stays consistent
    task automatic stage_byte(input logic [15:0] addr, output logic [7:0] val);
        bit seen;
        seen = 1'b0;
        foreach (chain_addrs[i])
            if (chain_addrs[i] == addr)
                seen = 1'b1;
        if (!seen)
        begin
            chain_addrs.push_back(addr);
            if (!sb.written[addr] || $urandom_range(3) != 0)
                write_byte(addr, pick_byte());
        end
        val = sb.mem[addr];
    endtask

    // Place every byte the opcode will read, then execute it
    task automatic exec_opcode(input logic [7:0] op);
        logic [7:0]  b0;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [7:0]  zp;
        logic [7:0]  skip;
        logic [15:0] pc0;
        logic [71:0] d;
        chain_addrs.delete();
        pc0 = sb.pc_reg;
        if (op == liu_pkg::OP_BIT_ZP || op == liu_pkg::OP_BIT_ABS)
        begin
            stage_byte(pc0, b0);
            if (op == liu_pkg::OP_BIT_ABS)
            begin
                stage_byte(pc0 + 16'd1, hi);
                stage_byte({hi, b0}, skip);
            end
            else
                stage_byte({8'h00, b0}, skip);
        end
        else if (op[1:0] == liu_pkg::CC_ALU && op[7:5] <= liu_pkg::GRP_EOR)
        begin
            stage_byte(pc0, b0);
            unique case (op[4:2])
                liu_pkg::MODE_IND_X:
                begin
                    zp = b0 + sb.x_reg;
                    stage_byte({8'h00, zp}, lo);
                    zp = zp + 8'd1;
                    stage_byte({8'h00, zp}, hi);
                    stage_byte({hi, lo}, skip);
                end
                liu_pkg::MODE_ZP:
                    stage_byte({8'h00, b0}, skip);
                liu_pkg::MODE_IMM: ;
                liu_pkg::MODE_ABS:
                begin
                    stage_byte(pc0 + 16'd1, hi);
                    stage_byte({hi, b0}, skip);
                end
                liu_pkg::MODE_IND_Y:
                begin
                    stage_byte({8'h00, b0}, lo);
                    zp = b0 + 8'd1;
                    stage_byte({8'h00, zp}, hi);
                    stage_byte({hi, lo} + {8'h00, sb.y_reg}, skip);
                end
                liu_pkg::MODE_ZP_X:
                begin
                    zp = b0 + sb.x_reg;
                    stage_byte({8'h00, zp}, skip);
                end
                liu_pkg::MODE_ABS_Y:
                begin
                    stage_byte(pc0 + 16'd1, hi);
                    stage_byte({hi, b0} + {8'h00, sb.y_reg}, skip);
                end
                default:
                begin
                    stage_byte(pc0 + 16'd1, hi);
                    stage_byte({hi, b0} + {8'h00, sb.x_reg}, skip);
                end
            endcase
        end
        d       = noise72();
        d[7:0]  = op;
        send(liu_pkg::KIND_EXEC, d);
    endtask

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // Receiver: random ready pattern with one long hold-off to back up the input side
    initial
    begin
        bit          pressed;
        int          r;
        int          len;
        logic        level;
        pressed  = 1'b0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!pressed && sb.results >= PRESSURE_AT)
            begin
                pressed  = 1'b1;
                m_tready <= 1'b0;
                repeat (PRESSURE_LEN) @(posedge clk);
            end
            r = $urandom_range(99);
            if (r < 60)
            begin
                level = 1'b1;
                len   = $urandom_range(r < 15 ? 60 : 20, 1);
            end
            else if (r < 95)
            begin
                level = 1'b0;
                len   = $urandom_range(3, 1);
            end
            else
            begin
                level = 1'b0;
                len   = $urandom_range(40, 10);
            end
            m_tready <= level;
            repeat (len) @(posedge clk);
        end
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench: errors");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin
        int start;
        int r;
        sb       = new();
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= liu_pkg::KIND_MEM_WR;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ignored kind, unhandled opcodes, register and memory extremes
        send(KIND_IGNORED, noise72());
        exec_opcode(OP_BRK);
        exec_opcode(OP_ALL_ONES);
        exec_opcode(OP_ADC_IMM);
        write_byte(16'hFFFF, 8'hFF);
        write_byte(16'h0000, 8'h00);
        set_regs(8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        exec_opcode({liu_pkg::GRP_AND, liu_pkg::MODE_IMM, liu_pkg::CC_ALU});
        exec_opcode({liu_pkg::GRP_ORA, liu_pkg::MODE_IND_X, liu_pkg::CC_ALU});
        exec_opcode({liu_pkg::GRP_EOR, liu_pkg::MODE_IND_Y, liu_pkg::CC_ALU});
        exec_opcode({liu_pkg::GRP_AND, liu_pkg::MODE_ABS_Y, liu_pkg::CC_ALU});
        exec_opcode({liu_pkg::GRP_ORA, liu_pkg::MODE_ZP_X, liu_pkg::CC_ALU});
        set_regs(8'h00, 8'h00, 8'h00, 16'h0000);
        exec_opcode({liu_pkg::GRP_ORA, liu_pkg::MODE_IMM, liu_pkg::CC_ALU});
        exec_opcode({liu_pkg::GRP_AND, liu_pkg::MODE_ZP, liu_pkg::CC_ALU});
        exec_opcode({liu_pkg::GRP_EOR, liu_pkg::MODE_ABS, liu_pkg::CC_ALU});
        exec_opcode({liu_pkg::GRP_ORA, liu_pkg::MODE_ABS_X, liu_pkg::CC_ALU});
        exec_opcode(liu_pkg::OP_BIT_ZP);
        set_regs(8'h5A, 8'h80, 8'h01, 16'h8000);
        exec_opcode(liu_pkg::OP_BIT_ABS);
        exec_opcode({liu_pkg::GRP_EOR, liu_pkg::MODE_IND_X, liu_pkg::CC_ALU});

        // Random: mostly well-formed opcodes with their bytes placed, some noise
        start = sb.items;
        while (sb.items - start < RANDOM_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 8)
                set_regs(pick_byte(), pick_byte(), pick_byte(), pick_pc());
            else if (r < 13)
                write_byte(16'($urandom_range(65535)), 8'($urandom_range(255)));
            else if (r < 16)
                send(KIND_IGNORED, noise72());
            else if (r < 26)
                exec_opcode(8'($urandom_range(255)));
            else
                exec_opcode(pick_legal());
        end
        s_tvalid <= 1'b0;

        // Drain, then let the pipeline settle
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("run covered %0d executes (%0d unhandled), %0d memory writes, %0d %s",
                 sb.n_exec, sb.n_bad, sb.n_wr, sb.n_set, "register loads");
        $display("%0d results checked, %0d mismatches, %0d cycles",
                 sb.results, sb.errors, cycles);
        if (sb.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/liu_pkg.sv
rtl/liu_ctrl.sv
rtl/liu_datapath.sv
rtl/logical_instruction_unit.sv
tb/sv/testbench.sv
